// File: rtl/wpt_pkg.sv
// Shared types and constants for the waypoint PD tracker.
// Used by waypoint_pd_tracker and wpt_pd_unit; depends on nothing.
`default_nettype none
package wpt_pkg;

  localparam int PATH_DEPTH = 256;
  localparam int PATH_AW = $clog2(PATH_DEPTH);
  localparam int PATH_CW = PATH_AW + 1;

  localparam int MUL_STEPS = 16;
  localparam int DIV_STEPS = 49;
  localparam int ACC_W = 60;

  localparam logic [1:0] REQ_FIX = 2'd0;
  localparam logic [1:0] REQ_LOAD = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;
  localparam logic [1:0] REQ_STOP = 2'd3;

  localparam logic [2:0] CFG_GAIN_PROP = 3'd0;
  localparam logic [2:0] CFG_GAIN_PROP_YAW = 3'd1;
  localparam logic [2:0] CFG_GAIN_DERIV = 3'd2;
  localparam logic [2:0] CFG_GAIN_DERIV_YAW = 3'd3;
  localparam logic [2:0] CFG_YAW_ONLY = 3'd4;

  localparam logic [40:0] DERIV_CLAMP = 41'h100_0000_0000;

  typedef struct packed {
    logic signed [31:0] err;
    logic signed [32:0] diff;
    logic               use_d;
  } pd_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -33'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/waypoint_pd_tracker.sv
// Waypoint PD tracker: a position fix that produces a command runs two passes of the shared
// multiply and divide unit, one per axis; with the derivative term a pass also divides by
// the interval, which a zero interval skips. No new word is taken until the command is
// presented, and an output stall holds it longer. Other fixes and loads are taken in idle;
// start and stop present a zero word. Synchronous reset clears the queue pointers, flags and
// stored errors and resets the gains (proportional to 26, derivative to 0); the queue RAM is not cleared.
`default_nettype none
module waypoint_pd_tracker import wpt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  req_type,
  input  wire logic signed [31:0] coord_x,
  input  wire logic signed [31:0] coord_y,
  input  wire logic signed [15:0] heading,
  input  wire logic        [15:0] time_step,
  input  wire logic               path_start,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [31:0] vel_x,
  output logic signed      [31:0] vel_y,
  output logic signed      [31:0] vel_yaw,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [15:0] cfg_data
);

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_RD = 3'd1;
  localparam logic [2:0] T_WX = 3'd2;
  localparam logic [2:0] T_WY = 3'd3;
  localparam logic [2:0] T_OUT = 3'd4;

  logic [2:0] state;
  logic [PATH_AW-1:0] head;
  logic [PATH_CW-1:0] count;
  logic fix_seen, tracking_on, new_target;
  logic signed [31:0] last_x, last_y;
  logic [15:0] gain_prop, gain_deriv;
  logic signed [31:0] px, py, ey_r, res_x, res_y;
  logic signed [32:0] dy_r;
  logic [15:0] dt;
  logic use_d;

  logic accept;
  logic [PATH_AW-1:0] head_pop, waddr;
  logic [PATH_CW-1:0] count_eff;
  logic we;
  logic [63:0] rdata;
  logic signed [31:0] ex_c, ey_c;
  logic out_free;

  logic unit_start, unit_done;
  pd_req_t unit_req;
  logic signed [31:0] unit_res;

  assign in_stall = (state != T_IDLE);
  assign accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || !out_stall;

  assign head_pop = (count > PATH_CW'(1)) ? head + PATH_AW'(1) : head;
  assign count_eff = path_start ? '0 : count;
  assign waddr = path_start ? '0 : head + count[PATH_AW-1:0];
  assign we = accept && (req_type == REQ_LOAD) && (count_eff != PATH_CW'(PATH_DEPTH));

  wpt_ram #(.WIDTH(64), .DEPTH(PATH_DEPTH)) u_path (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata({coord_y, coord_x}),
    .raddr(head_pop),
    .rdata(rdata)
  );

  assign ex_c = sat32(33'(signed'(rdata[31:0])) - 33'(px));
  assign ey_c = sat32(33'(signed'(rdata[63:32])) - 33'(py));

  always_comb begin
    unit_start = 1'b0;
    unit_req.err = ex_c;
    unit_req.diff = 33'(ex_c) - 33'(last_x);
    unit_req.use_d = use_d;
    if (state == T_RD) begin
      unit_start = 1'b1;
    end else if (state == T_WX && unit_done) begin
      unit_start = 1'b1;
      unit_req.err = ey_r;
      unit_req.diff = dy_r;
    end
  end

  wpt_pd_unit u_pd (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .req   (unit_req),
    .dt    (dt),
    .kp    (gain_prop),
    .kd    (gain_deriv),
    .done  (unit_done),
    .result(unit_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop <= 16'd26;
      gain_deriv <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN_PROP: gain_prop <= cfg_data;
        CFG_GAIN_DERIV: gain_deriv <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      head <= '0;
      count <= '0;
      fix_seen <= 1'b0;
      tracking_on <= 1'b0;
      new_target <= 1'b1;
      last_x <= '0;
      last_y <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != T_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            unique case (req_type) inside
              REQ_LOAD: begin
                if (path_start) begin
                  head <= '0;
                end
                count <= (count_eff != PATH_CW'(PATH_DEPTH)) ? count_eff + PATH_CW'(1)
                                                            : count_eff;
              end
              REQ_START, REQ_STOP: begin
                tracking_on <= (req_type == REQ_START);
                last_x <= '0;
                last_y <= '0;
                if (req_type == REQ_START) begin
                  new_target <= 1'b1;
                end else begin
                  head <= '0;
                  count <= '0;
                end
                res_x <= '0;
                res_y <= '0;
                state <= T_OUT;
              end
              default: begin
                if (!fix_seen) begin
                  fix_seen <= 1'b1;
                end else if (tracking_on && count != '0) begin
                  head <= head_pop;
                  if (count > PATH_CW'(1)) begin
                    count <= count - PATH_CW'(1);
                  end
                  px <= coord_x;
                  py <= coord_y;
                  dt <= time_step;
                  use_d <= !new_target;
                  new_target <= 1'b0;
                  state <= T_RD;
                end
              end
            endcase
          end
        end
        T_RD: begin
          ey_r <= ey_c;
          dy_r <= 33'(ey_c) - 33'(last_y);
          last_x <= ex_c;
          last_y <= ey_c;
          state <= T_WX;
        end
        T_WX: begin
          if (unit_done) begin
            res_x <= unit_res;
            state <= T_WY;
          end
        end
        T_WY: begin
          if (unit_done) begin
            res_y <= unit_res;
            state <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_free) begin
            vel_x <= res_x;
            vel_y <= res_y;
            vel_yaw <= '0;
            out_valid <= 1'b1;
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  logic unused_heading;
  assign unused_heading = ^heading;

endmodule
`default_nettype wire

// File: rtl/wpt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module wpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/wpt_pd_unit.sv
// Shared PD arithmetic unit: shift-add multiplier on one accumulator and
// restoring divider. Depends on wpt_pkg.
`default_nettype none
module wpt_pd_unit import wpt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire pd_req_t            req,
  input  wire logic        [15:0] dt,
  input  wire logic        [15:0] kp,
  input  wire logic        [15:0] kd,
  output logic                    done,
  output logic signed      [31:0] result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULP = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_QSET = 3'd3;
  localparam logic [2:0] S_MULD = 3'd4;
  localparam logic [2:0] S_FIN = 3'd5;

  logic [2:0] state;
  logic [5:0] cnt;
  logic [48:0] num;
  logic [15:0] rem;
  logic [48:0] qmag;
  logic neg;
  logic use_d;
  logic [15:0] dt_r;
  logic [15:0] kd_r;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] mcand;
  logic [15:0] mplier;

  logic [32:0] diff_abs;
  logic [16:0] rem_sh;
  logic rem_ge;
  logic [40:0] qclamp;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-9:0] acc_sh;

  assign diff_abs = req.diff[32] ? 33'(-req.diff) : 33'(req.diff);
  assign rem_sh = {rem, num[48]};
  assign rem_ge = rem_sh >= {1'b0, dt_r};
  assign qclamp = (qmag > 49'(DERIV_CLAMP)) ? DERIV_CLAMP : qmag[40:0];
  assign acc_rnd = acc + ACC_W'(128);
  assign acc_sh = acc_rnd[ACC_W-1:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      unique case (state) inside
        S_IDLE: begin
          if (start) begin
            num <= {diff_abs, 16'd0};
            neg <= req.diff[32];
            use_d <= req.use_d;
            dt_r <= dt;
            kd_r <= kd;
            acc <= '0;
            mcand <= ACC_W'(req.err);
            mplier <= kp;
            cnt <= '0;
            state <= S_MULP;
          end
        end
        S_MULP, S_MULD: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand <= mcand <<< 1;
          mplier <= mplier >> 1;
          if (cnt == 6'(MUL_STEPS - 1)) begin
            cnt <= '0;
            rem <= '0;
            if (state == S_MULD || !use_d) begin
              state <= S_FIN;
            end else if (dt_r == 16'd0) begin
              qmag <= (num != '0) ? 49'(DERIV_CLAMP) << 1 : '0;
              state <= S_QSET;
            end else begin
              state <= S_DIV;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DIV: begin
          rem <= rem_ge ? 16'(rem_sh - {1'b0, dt_r}) : rem_sh[15:0];
          qmag <= {qmag[47:0], rem_ge};
          num <= num << 1;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DIV_STEPS - 1)) begin
            state <= S_QSET;
          end
        end
        S_QSET: begin
          mcand <= neg ? -ACC_W'(qclamp) : ACC_W'(qclamp);
          mplier <= kd_r;
          cnt <= '0;
          state <= S_MULD;
        end
        S_FIN: begin
          if (acc_sh > (ACC_W-8)'(32'sh7FFF_FFFF)) begin
            result <= 32'sh7FFF_FFFF;
          end else if (acc_sh < -(ACC_W-8)'(33'sh0_8000_0000)) begin
            result <= 32'sh8000_0000;
          end else begin
            result <= acc_sh[31:0];
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
